// ----- src/fmcd_pkg.sv -----
package fmcd_pkg;

	// divider word format
	localparam int FRAC_BITS = 12;
	localparam int WORD_W    = 24;
	localparam int SHIFT_W   = FRAC_BITS + 1;
	localparam int QUOT_W    = 2 * SHIFT_W;
	localparam int CNT_W     = $clog2(QUOT_W);
	localparam logic [QUOT_W-1:0] SAT_LIMIT =
		QUOT_W'((2 ** (2 * FRAC_BITS + 1)) - (2 ** FRAC_BITS));

	// configuration register widths
	localparam int CENTER_W   = 28;
	localparam int SPREAD_W   = 24;
	localparam int PLL_W      = 30;
	localparam int SLEW_W     = 24;
	localparam int OFFSET_W   = 24;
	localparam int CFG_DATA_W = 30;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CENTER_W-1:0] CENTER_RESET = CENTER_W'(100000000);
	localparam logic [SPREAD_W-1:0] SPREAD_RESET = '0;
	localparam logic [PLL_W-1:0]    PLL_RESET    = PLL_W'(500000000);
	localparam logic [SLEW_W-1:0]   SLEW_RESET   = SLEW_W'(3000000);
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(50000);

	// datapath widths, set by the ramp products
	localparam int ELAPSED_W = 25;
	localparam int K_W       = 24;
	localparam int MA_W      = 31;
	localparam int MB_W      = 25;
	localparam int MP_W      = MA_W + MB_W;
	localparam int NUM_W     = 54;
	localparam int T_W       = 54;
	localparam int DEN_W     = T_W - 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNTQ_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_OFF  = 2'd0,
		PH_UP   = 2'd1,
		PH_ON   = 2'd2,
		PH_DOWN = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER = 3'd0,
		REG_SPREAD = 3'd1,
		REG_PLL    = 3'd2,
		REG_SLEW   = 3'd3,
		REG_OFFSET = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [CENTER_W-1:0] center_freq_hz;
		logic [SPREAD_W-1:0] spread_hz;
		logic [PLL_W-1:0]    pll_freq_hz;
		logic [SLEW_W-1:0]   slew_time_us;
		logic [OFFSET_W-1:0] soft_offset_hz;
	} cfg_t;

	typedef enum logic [1:0] {
		K_HOLD,
		K_RAMP,
		K_SAMPLE
	} kind_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_DIV,
		CMD_ZERO,
		CMD_ONE
	} cmd_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL0,
		F_MUL1,
		F_MUL2,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_WAIT
	} back_state_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		phase_t           phase;
		logic             enable;
	} entry_t;

endpackage

// ----- src/fmcd_if.sv -----
interface fmcd_tick_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          sample_valid;
	logic                          start_request;
	logic                          stop_request;

	modport source (
		output valid, sample, sample_valid, start_request, stop_request,
		input  ready
	);
	modport sink (
		input  valid, sample, sample_valid, start_request, stop_request,
		output ready
	);
endinterface

interface fmcd_result_if import fmcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] divisor_word;
	logic              clock_enable;
	logic [1:0]        phase;

	modport source (
		output valid, divisor_word, clock_enable, phase,
		input  ready
	);
	modport sink (
		input  valid, divisor_word, clock_enable, phase,
		output ready
	);
endinterface

// ----- src/fm_clock_divisor_modulator_top.sv -----
// fm clock divisor modulator
// ticks: one transfer per microsecond tick, carrying an optional audio sample
// (sample, sample_valid) and start/stop requests. results: one transfer per
// tick with the 12.12 divider word, clock enable and phase after that tick.
// cfg_we/cfg_index/cfg_wdata write the five setup registers; write them only
// while no tick is in flight.
// the front takes a tick, steps the off/ramp up/on/ramp down machine and,
// unless the tick only holds the word, runs three products through one
// shared multiplier, then hands the job to a two-entry queue. the back
// divides one quotient bit per cycle. a retuning tick passes through the
// multiplier states, the queue and the back's 26-step divider, which limits
// the sustained rate; ticks that only hold the word skip multiplier and divider.
// reset returns the phase to off with the clock disabled, word 0, and the
// setup registers to their defaults. a stalled result stays in the output
// register; the queue keeps filling until full, then ticks are held off.
module fm_clock_divisor_modulator_top import fmcd_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	fmcd_tick_if.sink             ticks,
	fmcd_result_if.source         results
);

	cfg_t   cfg_q;
	logic   push, full, pop, empty;
	entry_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_freq_hz <= CENTER_RESET;
			cfg_q.spread_hz      <= SPREAD_RESET;
			cfg_q.pll_freq_hz    <= PLL_RESET;
			cfg_q.slew_time_us   <= SLEW_RESET;
			cfg_q.soft_offset_hz <= OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_CENTER: cfg_q.center_freq_hz <= cfg_wdata[CENTER_W-1:0];
				REG_SPREAD: cfg_q.spread_hz      <= cfg_wdata[SPREAD_W-1:0];
				REG_PLL:    cfg_q.pll_freq_hz    <= cfg_wdata[PLL_W-1:0];
				REG_SLEW:   cfg_q.slew_time_us   <= cfg_wdata[SLEW_W-1:0];
				REG_OFFSET: cfg_q.soft_offset_hz <= cfg_wdata[OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fmcd_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ticks     (ticks),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	fmcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	fmcd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty),
		.results  (results)
	);

endmodule

// ----- src/fmcd_front.sv -----
module fmcd_front import fmcd_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	fmcd_tick_if.sink     ticks,
	output logic          push,
	output entry_t        push_data,
	input  logic          full
);

	localparam logic [MB_W-1:0] SAMPLE_SCALE = MB_W'(1) << (SAMPLE_BITS - 1);

	front_state_t fstate_q, fstate_next;
	phase_t       phase_q, nxt_phase;
	logic [ELAPSED_W-1:0] elapsed_q, nxt_elapsed, elapsed_inc;
	logic         en_q, nxt_en;
	kind_t        kind_q, nxt_kind;
	logic [K_W-1:0] k_q, nxt_k;
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic         accept, ramp_done;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [MP_W-1:0] mul_p;
	logic [MB_W-1:0]        scale;
	logic [NUM_W-1:0]       a_q;
	logic signed [T_W-1:0]  c_q, d_q, t_sum;

	assign accept      = ticks.valid && ticks.ready;
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + ELAPSED_W'(1);
	assign ramp_done   = elapsed_inc >= ELAPSED_W'(cfg.slew_time_us);

	// phase machine update for one tick
	always_comb begin
		nxt_phase   = phase_q;
		nxt_elapsed = elapsed_q;
		nxt_en      = en_q;
		nxt_kind    = K_HOLD;
		nxt_k       = '0;
		case (phase_q)
			PH_OFF: begin
				if (ticks.start_request) begin
					nxt_en      = 1'b1;
					nxt_elapsed = '0;
					nxt_phase   = PH_UP;
					nxt_kind    = K_RAMP;
					nxt_k       = cfg.slew_time_us;
				end
			end
			PH_UP: begin
				nxt_elapsed = elapsed_inc;
				nxt_kind    = K_RAMP;
				if (ramp_done) begin
					nxt_phase = PH_ON;
				end else begin
					nxt_k = cfg.slew_time_us - elapsed_inc[K_W-1:0];
				end
			end
			PH_ON: begin
				if (ticks.stop_request) begin
					nxt_elapsed = '0;
					nxt_phase   = PH_DOWN;
					nxt_kind    = K_RAMP;
				end else if (ticks.sample_valid) begin
					nxt_kind = K_SAMPLE;
				end
			end
			PH_DOWN: begin
				nxt_elapsed = elapsed_inc;
				nxt_kind    = K_RAMP;
				if (ramp_done) begin
					nxt_k     = cfg.slew_time_us;
					nxt_en    = 1'b0;
					nxt_phase = PH_OFF;
				end else begin
					nxt_k = elapsed_inc[K_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		fstate_next = fstate_q;
		case (fstate_q)
			F_IDLE: begin
				if (accept) begin
					fstate_next = (nxt_kind == K_HOLD) ? F_PUSH : F_MUL0;
				end
			end
			F_MUL0: fstate_next = F_MUL1;
			F_MUL1: fstate_next = F_MUL2;
			F_MUL2: fstate_next = F_PUSH;
			F_PUSH: begin
				if (!full) begin
					fstate_next = F_IDLE;
				end
			end
			default: fstate_next = F_IDLE;
		endcase
	end

	// shared multiplier: numerator, center term, then offset or deviation term
	always_comb begin
		ticks.ready = (fstate_q == F_IDLE);
		push        = (fstate_q == F_PUSH) && !full;
		scale       = (kind_q == K_RAMP) ? MB_W'(cfg.slew_time_us) : SAMPLE_SCALE;
		mul_a       = '0;
		mul_b       = '0;
		case (fstate_q)
			F_MUL0: begin
				mul_a = MA_W'(cfg.pll_freq_hz);
				mul_b = scale;
			end
			F_MUL1: begin
				mul_a = MA_W'(cfg.center_freq_hz);
				mul_b = scale;
			end
			F_MUL2: begin
				if (kind_q == K_RAMP) begin
					mul_a = MA_W'(cfg.soft_offset_hz);
					mul_b = MB_W'(k_q);
				end else begin
					mul_a = MA_W'(cfg.spread_hz);
					mul_b = MB_W'(smp_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign t_sum = c_q + d_q;

	always_comb begin
		push_data.num    = a_q;
		push_data.den    = t_sum[DEN_W-1:0];
		push_data.phase  = phase_q;
		push_data.enable = en_q;
		if (kind_q == K_HOLD) begin
			push_data.cmd = CMD_HOLD;
		end else if (cfg.pll_freq_hz == '0) begin
			push_data.cmd = CMD_ONE;
		end else if (t_sum == '0) begin
			push_data.cmd = CMD_ZERO;
		end else if (t_sum < 0) begin
			push_data.cmd = CMD_ONE;
		end else if (a_q == '0) begin
			push_data.cmd = CMD_ONE;
		end else begin
			push_data.cmd = CMD_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstate_q  <= F_IDLE;
			phase_q   <= PH_OFF;
			elapsed_q <= '0;
			en_q      <= 1'b0;
		end else begin
			fstate_q <= fstate_next;
			if (accept) begin
				phase_q   <= nxt_phase;
				elapsed_q <= nxt_elapsed;
				en_q      <= nxt_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= nxt_kind;
			k_q    <= nxt_k;
			smp_q  <= ticks.sample;
		end
		case (fstate_q)
			F_MUL0: a_q <= mul_p[NUM_W-1:0];
			F_MUL1: c_q <= mul_p[T_W-1:0];
			F_MUL2: d_q <= mul_p[T_W-1:0];
			default: begin
			end
		endcase
	end

endmodule

// ----- src/fmcd_queue.sv -----
module fmcd_queue import fmcd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t pop_data,
	output logic   empty
);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNTQ_W-1:0] count_q;

	assign full     = (count_q == CNTQ_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTQ_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTQ_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- src/fmcd_back.sv -----
module fmcd_back import fmcd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	output logic          pop,
	input  entry_t        pop_data,
	input  logic          empty,
	fmcd_result_if.source results
);

	back_state_t bstate_q, bstate_next;
	logic [WORD_W-1:0] word_q, start_word, final_word, divisor_q;
	phase_t            ph_q, out_phase_q;
	logic              en_q, out_en_q, out_valid_q;
	logic [DEN_W-1:0]  r_q, den_q, r_next;
	logic [QUOT_W-1:0] nl_q, q_q, q_next;
	logic [CNT_W-1:0]  cnt_q;
	logic [DEN_W:0]    r_shift;
	logic [QUOT_W:0]   q_round;
	logic              ovf, go_div, div_last, load_out, ge;

	assign ovf      = (pop_data.num >> SHIFT_W) >= NUM_W'(pop_data.den);
	assign div_last = (bstate_q == B_DIV) && (cnt_q == CNT_W'(QUOT_W - 1));

	// one restoring step per cycle
	assign r_shift = {r_q, nl_q[QUOT_W-1]};
	assign ge      = r_shift >= {1'b0, den_q};
	assign r_next  = ge ? DEN_W'(r_shift - {1'b0, den_q}) : DEN_W'(r_shift);
	assign q_next  = {q_q[QUOT_W-2:0], ge};
	assign q_round = (QUOT_W + 1)'(q_next) + (QUOT_W + 1)'(1);
	assign final_word = (q_next >= SAT_LIMIT) ? '0 : WORD_W'(q_round >> 1);

	always_comb begin
		case (pop_data.cmd)
			CMD_HOLD: start_word = divisor_q;
			CMD_ONE:  start_word = WORD_W'(1);
			default:  start_word = '0;
		endcase
	end

	always_comb begin
		bstate_next = bstate_q;
		case (bstate_q)
			B_IDLE: begin
				if (!empty) begin
					bstate_next = (pop_data.cmd == CMD_DIV && !ovf) ? B_DIV : B_WAIT;
				end
			end
			B_DIV: begin
				if (div_last) begin
					bstate_next = B_WAIT;
				end
			end
			B_WAIT: begin
				if (!out_valid_q || results.ready) begin
					bstate_next = B_IDLE;
				end
			end
			default: bstate_next = B_IDLE;
		endcase
	end

	always_comb begin
		pop                  = (bstate_q == B_IDLE) && !empty;
		go_div               = pop && (pop_data.cmd == CMD_DIV) && !ovf;
		load_out             = (bstate_q == B_WAIT) && (!out_valid_q || results.ready);
		results.valid        = out_valid_q;
		results.divisor_word = divisor_q;
		results.clock_enable = out_en_q;
		results.phase        = out_phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q    <= B_IDLE;
			out_valid_q <= 1'b0;
			divisor_q   <= '0;
			out_phase_q <= PH_OFF;
			out_en_q    <= 1'b0;
		end else begin
			bstate_q <= bstate_next;
			if (load_out) begin
				out_valid_q <= 1'b1;
				divisor_q   <= word_q;
				out_phase_q <= ph_q;
				out_en_q    <= en_q;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ph_q   <= pop_data.phase;
			en_q   <= pop_data.enable;
			word_q <= start_word;
		end
		if (go_div) begin
			r_q   <= DEN_W'(pop_data.num >> SHIFT_W);
			den_q <= pop_data.den;
			nl_q  <= {pop_data.num[SHIFT_W-1:0], SHIFT_W'(0)};
			q_q   <= '0;
			cnt_q <= '0;
		end
		if (bstate_q == B_DIV) begin
			r_q   <= r_next;
			nl_q  <= nl_q << 1;
			q_q   <= q_next;
			cnt_q <= cnt_q + CNT_W'(1);
			if (div_last) begin
				word_q <= final_word;
			end
		end
	end

endmodule

// ----- src/fmcd_checker.sv -----
module fmcd_props import fmcd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              tick_valid,
	input logic              tick_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [WORD_W-1:0] divisor_word,
	input logic              clock_enable,
	input logic [1:0]        phase
);

	logic [2:0] pending_q;
	logic       tick_xfer, res_xfer;

	assign tick_xfer = tick_valid && tick_ready;
	assign res_xfer  = res_valid && res_ready;

	// ticks taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (tick_xfer && !res_xfer) begin
			pending_q <= pending_q + 3'd1;
		end else if (res_xfer && !tick_xfer) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != 3'd0)
		else $error("result without an outstanding tick");

	a_enable_follows_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (clock_enable == (phase != PH_OFF)))
		else $error("clock enable disagrees with phase");

	a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		tick_xfer |=> !tick_ready)
		else $error("tick taken while previous one still in front");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(divisor_word))
		else $error("stalled result changed");

endmodule

bind fm_clock_divisor_modulator_top fmcd_props u_fmcd_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_valid   (ticks.valid),
	.tick_ready   (ticks.ready),
	.res_valid    (results.valid),
	.res_ready    (results.ready),
	.divisor_word (results.divisor_word),
	.clock_enable (results.clock_enable),
	.phase        (results.phase)
);
